// ===== sv/lff_pkg.sv =====
// ----------------------------------------------------------------------------
// lff_pkg
// Shared types and constants for the flame effect block: field widths,
// register indexes, cell operation codes and the cell control bundle.
// ----------------------------------------------------------------------------
package lff_pkg;

   localparam int MAX_CELLS = 64;
   localparam int CELL_W    = $clog2(MAX_CELLS);
   localparam int NCELL_W   = 7;

   localparam int COOL_W    = 10;
   localparam int ROLL_W    = 8;
   localparam int POS_W     = 3;
   localparam int HEAT_W    = 8;
   localparam int PIX_W     = 6;
   localparam int COLOR_W   = 8;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CELLS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARK_CHANCE = 1'b1;

   localparam logic [NCELL_W-1:0] NUM_CELLS_RESET    = 7'd60;
   localparam logic [HEAT_W-1:0]  SPARK_CHANCE_RESET = 8'd120;

   // divide by three as multiply and shift, exact for sums up to 765
   localparam int DIV3_MUL   = 683;
   localparam int DIV3_SHIFT = 11;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_COOL,
      OP_DRIFT,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [COOL_W-1:0]   cool;
      logic [CELL_W-1:0]   target;
      logic [CELL_W-1:0]   n_last;
      logic                spark_en;
      logic [POS_W-1:0]    spark_pos;
      logic [HEAT_W-1:0]   spark_amount;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRIFT,
      ST_EMIT
   } state_type;

endpackage

// ===== sv/lff_req_if.sv =====
// ----------------------------------------------------------------------------
// lff_req_if
// Input channel: one cooldown per cell plus the spark fields of a frame.
// ----------------------------------------------------------------------------
interface lff_req_if;
   import lff_pkg::*;

   logic                valid;
   logic                ready;
   logic [COOL_W-1:0]   cooldown;
   logic [ROLL_W-1:0]   spark_roll;
   logic [POS_W-1:0]    spark_pos;
   logic [HEAT_W-1:0]   spark_amount;

   modport source (output valid, cooldown, spark_roll, spark_pos, spark_amount,
                   input ready);
   modport sink   (input valid, cooldown, spark_roll, spark_pos, spark_amount,
                   output ready);
endinterface

// ===== sv/lff_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lff_rsp_if
// Result channel: one RGB color per cell with its index and a frame marker.
// ----------------------------------------------------------------------------
interface lff_rsp_if;
   import lff_pkg::*;

   logic                valid;
   logic                ready;
   logic [PIX_W-1:0]    pixel_index;
   logic [COLOR_W-1:0]  red;
   logic [COLOR_W-1:0]  green;
   logic [COLOR_W-1:0]  blue;
   logic                frame_last;

   modport source (output valid, pixel_index, red, green, blue, frame_last,
                   input ready);
   modport sink   (input valid, pixel_index, red, green, blue, frame_last,
                   output ready);
endinterface

// ===== sv/lff_cell.sv =====
// ----------------------------------------------------------------------------
// lff_cell
// One heat cell of the strip: cools when addressed, drifts from its two lower
// neighbors, takes a spark, and rotates toward cell zero during output.
// ----------------------------------------------------------------------------
module lff_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lff_pkg::CELL_W-1:0]    cell_idx,
   input  lff_pkg::cell_ctrl_type        ctrl,
   input  logic [lff_pkg::HEAT_W-1:0]    prev1_heat,
   input  logic [lff_pkg::HEAT_W-1:0]    prev2_heat,
   input  logic [lff_pkg::HEAT_W-1:0]    next_heat,
   input  logic [lff_pkg::HEAT_W-1:0]    wrap_heat,
   output logic [lff_pkg::HEAT_W-1:0]    heat
);
   import lff_pkg::*;

   localparam int SUM_W  = HEAT_W + 2;
   localparam int PROD_W = 2 * SUM_W;

   logic [HEAT_W-1:0] heat_ff, heat_in;
   logic [SUM_W-1:0]  drift_sum;
   logic [PROD_W-1:0] drift_prod;
   logic [HEAT_W-1:0] drift_val;
   logic [HEAT_W-1:0] drift_out;
   logic              in_drift;

   assign drift_sum  = SUM_W'(prev1_heat) + SUM_W'({prev2_heat, 1'b0});
   assign drift_prod = PROD_W'(drift_sum) * PROD_W'(DIV3_MUL);
   assign drift_val  = drift_prod[DIV3_SHIFT +: HEAT_W];
   assign in_drift   = (cell_idx >= CELL_W'(2)) && (cell_idx <= ctrl.n_last);

   always_comb begin
      drift_out = in_drift ? drift_val : heat_ff;
      if (ctrl.spark_en && (cell_idx == CELL_W'(ctrl.spark_pos))) begin
         drift_out = drift_out + ctrl.spark_amount;
      end
   end

   always_comb begin
      heat_in = heat_ff;
      case (ctrl.op)
         OP_COOL: begin
            if (cell_idx == ctrl.target) begin
               if (ctrl.cool > COOL_W'(heat_ff)) begin
                  heat_in = '0;
               end else begin
                  heat_in = heat_ff - HEAT_W'(ctrl.cool);
               end
            end
         end
         OP_DRIFT: begin
            heat_in = drift_out;
         end
         OP_SHIFT: begin
            if (cell_idx < ctrl.n_last) begin
               heat_in = next_heat;
            end else if (cell_idx == ctrl.n_last) begin
               heat_in = wrap_heat;
            end
         end
         default: begin
            heat_in = heat_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_ff <= '0;
      end else begin
         heat_ff <= heat_in;
      end
   end

   assign heat = heat_ff;

endmodule

// ===== sv/lff_color.sv =====
// ----------------------------------------------------------------------------
// lff_color
// Heat to color mapping with the result output register: scales the heat to
// 0..191, picks one of three bands and holds the color until transferred.
// ----------------------------------------------------------------------------
module lff_color (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [lff_pkg::HEAT_W-1:0]    heat_in,
   input  logic [lff_pkg::CELL_W-1:0]    cell_idx,
   input  logic                          last_in,
   output logic                          free,
   lff_rsp_if.source                     rsp_ch
);
   import lff_pkg::*;

   localparam int SCALE_W = 2 * HEAT_W;

   logic [SCALE_W-1:0] scaled;
   logic [SCALE_W-1:0] quot_sum;
   logic [HEAT_W-1:0]  t;
   logic [COLOR_W-1:0] ramp;
   logic [COLOR_W-1:0] r_c, g_c, b_c;

   logic               valid_ff, valid_in;
   logic [PIX_W-1:0]   pix_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic               last_ff;

   // round(h*191/255) as floor((h*191+127)/255), divide by 255 via x + x>>8 + 1
   assign scaled   = SCALE_W'(heat_in) * SCALE_W'(191) + SCALE_W'(127);
   assign quot_sum = scaled + (scaled >> HEAT_W) + SCALE_W'(1);
   assign t        = quot_sum[SCALE_W-1 -: HEAT_W];
   assign ramp     = {t[5:0], 2'b00};

   always_comb begin
      if (t > HEAT_W'(8'h80)) begin
         r_c = 8'hFF;
         g_c = 8'hFF;
         b_c = ramp;
      end else if (t > HEAT_W'(8'h40)) begin
         r_c = 8'hFF;
         g_c = ramp;
         b_c = '0;
      end else begin
         r_c = ramp;
         g_c = '0;
         b_c = '0;
      end
   end

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff   <= PIX_W'(cell_idx);
         red_ff   <= r_c;
         green_ff <= g_c;
         blue_ff  <= b_c;
         last_ff  <= last_in;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.pixel_index = pix_ff;
   assign rsp_ch.red         = red_ff;
   assign rsp_ch.green       = green_ff;
   assign rsp_ch.blue        = blue_ff;
   assign rsp_ch.frame_last  = last_ff;

endmodule

// ===== sv/led_fire_flame_effect.sv =====
// ----------------------------------------------------------------------------
// led_fire_flame_effect
// Flame animation over a strip of heat cells: cools one cell per transfer,
// and on the last cell of a frame drifts, sparks and emits every cell.
// ----------------------------------------------------------------------------
// a non-final transfer cools one cell and gives no result
// final transfer: cools the last cell; the drift state then drifts and sparks,
//   then the emit state rotates each cell through the color unit to the output
// frame: n cooling transfers, a drift step and n outputs; no cooldown is taken
//   while drifting or emitting, and output stalls stretch the output phase
// reset: synchronous, clears all heat cells, cell counter and output valid
// ----------------------------------------------------------------------------
module led_fire_flame_effect (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lff_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lff_pkg::CSR_DAT_W-1:0]    csr_wdata,
   lff_req_if.sink                          req_ch,
   lff_rsp_if.source                        rsp_ch
);
   import lff_pkg::*;

   logic [NCELL_W-1:0] num_cells_ff;
   logic [HEAT_W-1:0]  spark_chance_ff;

   logic [NCELL_W-1:0] n_eff;
   logic [CELL_W-1:0]  n_last;

   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  counter_ff, counter_in;
   logic [CELL_W-1:0]  emit_cnt_ff, emit_cnt_in;
   logic               spark_en_ff;
   logic [POS_W-1:0]   spark_pos_ff;
   logic [HEAT_W-1:0]  spark_amount_ff;

   logic               req_xfer;
   logic               is_last;
   logic               color_free;
   logic               color_load;
   logic               emit_done;
   logic               spark_hit;
   cell_ctrl_type      ctrl;

   logic [HEAT_W-1:0]  heat_w [MAX_CELLS];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_cells_ff    <= NUM_CELLS_RESET;
         spark_chance_ff <= SPARK_CHANCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_CELLS:    num_cells_ff    <= csr_wdata[NCELL_W-1:0];
            CSR_SPARK_CHANCE: spark_chance_ff <= csr_wdata[HEAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (num_cells_ff == '0) begin
         n_eff = NCELL_W'(1);
      end else if (num_cells_ff > NCELL_W'(MAX_CELLS)) begin
         n_eff = NCELL_W'(MAX_CELLS);
      end else begin
         n_eff = num_cells_ff;
      end
   end

   assign n_last    = CELL_W'(n_eff - NCELL_W'(1));
   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign is_last   = counter_ff >= n_last;
   assign emit_done = color_free && (emit_cnt_ff == n_last);
   assign spark_hit = (req_ch.spark_roll < spark_chance_ff)
                      && (NCELL_W'(req_ch.spark_pos) < n_eff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_xfer && is_last) state_in = ST_DRIFT;
         ST_DRIFT: state_in = ST_EMIT;
         ST_EMIT:  if (emit_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready      = 1'b0;
      color_load        = 1'b0;
      ctrl.op           = OP_HOLD;
      ctrl.cool         = req_ch.cooldown;
      ctrl.target       = is_last ? n_last : counter_ff;
      ctrl.n_last       = n_last;
      ctrl.spark_en     = spark_en_ff;
      ctrl.spark_pos    = spark_pos_ff;
      ctrl.spark_amount = spark_amount_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) ctrl.op = OP_COOL;
         end
         ST_DRIFT: begin
            ctrl.op = OP_DRIFT;
         end
         ST_EMIT: begin
            if (color_free) begin
               color_load = 1'b1;
               ctrl.op    = OP_SHIFT;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      counter_in  = counter_ff;
      emit_cnt_in = emit_cnt_ff;
      if (req_xfer) begin
         counter_in = is_last ? '0 : counter_ff + CELL_W'(1);
      end
      if (state_ff == ST_DRIFT) begin
         emit_cnt_in = '0;
      end else if (color_load) begin
         emit_cnt_in = emit_cnt_ff + CELL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         counter_ff  <= '0;
         emit_cnt_ff <= '0;
         spark_en_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         counter_ff  <= counter_in;
         emit_cnt_ff <= emit_cnt_in;
         if (req_xfer && is_last) spark_en_ff <= spark_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && is_last) begin
         spark_pos_ff    <= req_ch.spark_pos;
         spark_amount_ff <= req_ch.spark_amount;
      end
   end

   // row of heat cells
   for (genvar k = 0; k < MAX_CELLS; k++) begin : g_cell
      logic [HEAT_W-1:0] p1, p2, nx;
      if (k >= 1) begin : g_p1
         assign p1 = heat_w[k-1];
      end else begin : g_p1_none
         assign p1 = '0;
      end
      if (k >= 2) begin : g_p2
         assign p2 = heat_w[k-2];
      end else begin : g_p2_none
         assign p2 = '0;
      end
      if (k < MAX_CELLS - 1) begin : g_nx
         assign nx = heat_w[k+1];
      end else begin : g_nx_none
         assign nx = '0;
      end

      lff_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (CELL_W'(k)),
         .ctrl       (ctrl),
         .prev1_heat (p1),
         .prev2_heat (p2),
         .next_heat  (nx),
         .wrap_heat  (heat_w[0]),
         .heat       (heat_w[k])
      );
   end

   lff_color u_color (
      .clock    (clock),
      .reset    (reset),
      .load     (color_load),
      .heat_in  (heat_w[0]),
      .cell_idx (emit_cnt_ff),
      .last_in  (emit_cnt_ff == n_last),
      .free     (color_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== test/led_fire_flame_effect_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_fire_flame_effect_tb
// Drives cooldown transfers into the flame block and checks every pixel
// against a cycle-free model of the heat store: cooling, upward drift,
// sparks and the three-band color ramp. A short table of directed steps
// covers the register extremes, out-of-strip sparks, large cooldowns and a
// strip shrunk mid-frame; random phases follow with idle bursts, a long
// output stall and a final stretch at full rate.
// ----------------------------------------------------------------------------
module led_fire_flame_effect_tb;
   import lff_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int LONG_HOLD     = 300;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               frame_last;
   } pixel_type;

   typedef struct packed {
      logic [COOL_W-1:0] cooldown;
      logic [ROLL_W-1:0] roll;
      logic [POS_W-1:0]  pos;
      logic [HEAT_W-1:0] amount;
   } cell_item_type;

   typedef enum logic {
      ROW_CFG,
      ROW_ITEM
   } row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DAT_W-1:0]   data;
      cell_item_type          item;
      bit                     dark;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_wdata;

   lff_req_if req_ch ();
   lff_rsp_if rsp_ch ();

   led_fire_flame_effect DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // model state
   logic [HEAT_W-1:0]  heat_cells [MAX_CELLS];
   int unsigned        next_cell;
   logic [NCELL_W-1:0] cells_setting;
   logic [HEAT_W-1:0]  chance_setting;
   pixel_type          expected_pixels [$];

   int  mismatches;
   int  watchdog_cycles;
   bit  idle_en;
   bit  hold_armed;
   row_type steps [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pixel_type color_of(int unsigned idx, logic [HEAT_W-1:0] h, bit last);
      int unsigned t;
      logic [COLOR_W-1:0] ramp;
      pixel_type p;
      t = (h * 32'd191 + 32'd127) / 32'd255;
      ramp = 8'((t & 'h3F) << 2);
      p.pixel_index = idx[PIX_W-1:0];
      p.frame_last = last;
      if (t > 'h80) begin
         p.red = 8'hFF; p.green = 8'hFF; p.blue = ramp;
      end else if (t > 'h40) begin
         p.red = 8'hFF; p.green = ramp; p.blue = 8'h00;
      end else begin
         p.red = ramp; p.green = 8'h00; p.blue = 8'h00;
      end
      return p;
   endfunction

   function automatic void advance_flame(cell_item_type it, bit dark);
      int unsigned n;
      int unsigned c;
      int unsigned k;
      int unsigned sum;
      pixel_type p;
      n = (cells_setting == 0) ? 1 : ((cells_setting > MAX_CELLS) ? MAX_CELLS : cells_setting);
      c = (next_cell >= n - 1) ? n - 1 : next_cell;
      if (it.cooldown > heat_cells[c])
         heat_cells[c] = '0;
      else
         heat_cells[c] = heat_cells[c] - it.cooldown[HEAT_W-1:0];
      if (c < n - 1) begin
         next_cell = c + 1;
         return;
      end
      // drift upward, top cell first
      for (k = n - 1; k >= 2; k--) begin
         sum = heat_cells[k-1] + 2 * heat_cells[k-2];
         heat_cells[k] = 8'(sum / 3);
      end
      if (it.roll < chance_setting && it.pos < n)
         heat_cells[it.pos] = heat_cells[it.pos] + it.amount;
      for (k = 0; k < n; k++) begin
         p = color_of(k, heat_cells[k], k == n - 1);
         if (dark) begin
            p.red = 8'h00; p.green = 8'h00; p.blue = 8'h00;
         end
         expected_pixels.push_back(p);
      end
      next_cell = 0;
   endfunction

   function automatic row_type cfg_row(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
      row_type r;
      r.kind = ROW_CFG;
      r.index = index;
      r.data = data;
      r.item = '0;
      r.dark = 1'b0;
      return r;
   endfunction

   function automatic row_type item_row(logic [COOL_W-1:0] cool, logic [ROLL_W-1:0] roll,
                                        logic [POS_W-1:0] pos, logic [HEAT_W-1:0] amount,
                                        bit dark);
      row_type r;
      r.kind = ROW_ITEM;
      r.index = '0;
      r.data = '0;
      r.item.cooldown = cool;
      r.item.roll = roll;
      r.item.pos = pos;
      r.item.amount = amount;
      r.dark = dark;
      return r;
   endfunction

   function automatic cell_item_type random_item();
      cell_item_type it;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
         it.cooldown = COOL_W'($urandom_range(0, 40));
      else if (sel < 9)
         it.cooldown = COOL_W'($urandom_range(0, 551));
      else
         it.cooldown = COOL_W'($urandom_range(0, 1023));
      it.roll = ROLL_W'($urandom_range(0, 255));
      it.pos = POS_W'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0)
         it.amount = HEAT_W'($urandom_range(160, 254));
      else
         it.amount = HEAT_W'($urandom_range(0, 255));
      return it;
   endfunction

   task automatic send_item(cell_item_type it, bit dark);
      int gap;
      @(negedge clock);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cooldown <= it.cooldown;
      req_ch.spark_roll <= it.roll;
      req_ch.spark_pos <= it.pos;
      req_ch.spark_amount <= it.amount;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      advance_flame(it, dark);
   endtask

   // stop offering, wait for every pixel, then let the block finish its pass
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_NUM_CELLS:    cells_setting = data[NCELL_W-1:0];
         CSR_SPARK_CHANCE: chance_setting = data;
         default: ;
      endcase
   endtask

   task automatic run_phase(logic [CSR_DAT_W-1:0] cells, logic [CSR_DAT_W-1:0] chance,
                            int count, int pause_at);
      int i;
      settle();
      write_register(CSR_NUM_CELLS, cells);
      write_register(CSR_SPARK_CHANCE, chance);
      for (i = 0; i < count; i++) begin
         if (i == pause_at)
            settle();
         send_item(random_item(), 1'b0);
      end
   endtask

   // result monitor
   initial begin
      pixel_type seen;
      pixel_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen.pixel_index = rsp_ch.pixel_index;
            seen.red = rsp_ch.red;
            seen.green = rsp_ch.green;
            seen.blue = rsp_ch.blue;
            seen.frame_last = rsp_ch.frame_last;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               $display("%0t: pixel transfer with none expected, actual %0d %h %h %h %b",
                        $time, seen.pixel_index, seen.red, seen.green, seen.blue,
                        seen.frame_last);
            end else begin
               want = expected_pixels.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  $display("%0t: pixel mismatch, expected %0d %h %h %h %b, actual %0d %h %h %h %b",
                           $time, want.pixel_index, want.red, want.green, want.blue,
                           want.frame_last, seen.pixel_index, seen.red, seen.green,
                           seen.blue, seen.frame_last);
               end
            end
         end
      end
   end

   // result side flow control
   initial begin
      int burst;
      bit level;
      burst = 0;
      level = 1'b1;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_armed && expected_pixels.size() != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_armed = 1'b0;
         end else if (!idle_en) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            if (burst == 0) begin
               level = 1'($urandom_range(0, 1));
               burst = $urandom_range(1, 17);
            end
            rsp_ch.ready <= level;
            burst--;
         end
      end
   end

   initial begin
      watchdog_cycles = 0;
      while (watchdog_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         watchdog_cycles++;
      end
      $display("led_fire_flame_effect_tb failed");
      $finish;
   end

   initial begin
      logic [CSR_DAT_W-1:0] rand_cells;
      logic [CSR_DAT_W-1:0] rand_chance;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cooldown = '0;
      req_ch.spark_roll = '0;
      req_ch.spark_pos = '0;
      req_ch.spark_amount = '0;
      mismatches = 0;
      idle_en = 1'b1;
      hold_armed = 1'b0;
      foreach (heat_cells[k]) heat_cells[k] = '0;
      next_cell = 0;
      cells_setting = NUM_CELLS_RESET;
      chance_setting = SPARK_CHANCE_RESET;

      // single cell, spark chance at its reset value
      steps.push_back(cfg_row(CSR_NUM_CELLS, 8'd1));
      steps.push_back(item_row(10'd0, 8'd200, 3'd0, 8'd160, 1'b1));
      steps.push_back(item_row(10'd551, 8'd120, 3'd0, 8'd254, 1'b1));
      steps.push_back(item_row(10'd0, 8'd119, 3'd0, 8'd160, 1'b0));
      // chance of zero never sparks, oversized cooldown empties the cell
      steps.push_back(cfg_row(CSR_SPARK_CHANCE, 8'd0));
      steps.push_back(item_row(10'd1023, 8'd0, 3'd0, 8'd255, 1'b1));
      steps.push_back(cfg_row(CSR_SPARK_CHANCE, 8'd255));
      steps.push_back(item_row(10'd0, 8'd254, 3'd0, 8'd254, 1'b0));
      steps.push_back(item_row(10'd100, 8'd255, 3'd7, 8'd0, 1'b0));
      // zero cell count behaves as one cell
      steps.push_back(cfg_row(CSR_NUM_CELLS, 8'd0));
      steps.push_back(item_row(10'd20, 8'd0, 3'd0, 8'd100, 1'b0));
      // eight cells, spark lands on the top position
      steps.push_back(cfg_row(CSR_NUM_CELLS, 8'd8));
      steps.push_back(cfg_row(CSR_SPARK_CHANCE, 8'd128));
      steps.push_back(item_row(10'd0, 8'd0, 3'd3, 8'd255, 1'b0));
      steps.push_back(item_row(10'd5, 8'd0, 3'd1, 8'd255, 1'b0));
      steps.push_back(item_row(10'd0, 8'd255, 3'd7, 8'd0, 1'b0));
      steps.push_back(item_row(10'd300, 8'd0, 3'd2, 8'd200, 1'b0));
      steps.push_back(item_row(10'd2, 8'd17, 3'd4, 8'd160, 1'b0));
      steps.push_back(item_row(10'd0, 8'd0, 3'd5, 8'd1, 1'b0));
      steps.push_back(item_row(10'd1, 8'd99, 3'd6, 8'd77, 1'b0));
      steps.push_back(item_row(10'd0, 8'd127, 3'd7, 8'd250, 1'b0));
      // partial frame, then the strip shrinks below the cell counter
      steps.push_back(item_row(10'd3, 8'd0, 3'd0, 8'd200, 1'b0));
      steps.push_back(item_row(10'd0, 8'd0, 3'd1, 8'd200, 1'b0));
      steps.push_back(item_row(10'd9, 8'd0, 3'd2, 8'd200, 1'b0));
      steps.push_back(item_row(10'd0, 8'd0, 3'd3, 8'd200, 1'b0));
      steps.push_back(cfg_row(CSR_NUM_CELLS, 8'd3));
      steps.push_back(item_row(10'd0, 8'd0, 3'd7, 8'd200, 1'b0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (steps[s]) begin
         if (steps[s].kind == ROW_CFG) begin
            settle();
            write_register(steps[s].index, steps[s].data);
         end else begin
            send_item(steps[s].item, steps[s].dark);
         end
      end

      // short frames under a long output stall, with a drain in the middle
      hold_armed = 1'b1;
      run_phase(8'd2, 8'd0, 11, 6);
      run_phase(8'd40, 8'd200, 40, -1);
      rand_cells = CSR_DAT_W'($urandom_range(3, 12));
      rand_chance = CSR_DAT_W'($urandom_range(0, 255));
      run_phase(rand_cells, rand_chance, 15, -1);
      // full rate to the end, cell count is clamped to the maximum
      idle_en = 1'b0;
      run_phase(8'hFF, 8'd255, 64, -1);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("led_fire_flame_effect_tb passed");
      else
         $display("led_fire_flame_effect_tb failed");
      $finish;
   end

endmodule
